### src/sfcd_pkg.sv
// sfcd_pkg: shared types, constants and the CRC-8 byte update for the
// sensor frame CRC decoder. No dependencies.
package sfcd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_SEED    = 8'hFF;
    localparam logic [3:0]  FRAME_LAST  = 4'd8;
    localparam logic [10:0] TEMP_SCALE  = 11'd1750;
    localparam logic [11:0] TEMP_OFFSET = 12'd450;
    localparam logic [6:0]  HUM_SCALE   = 7'd100;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;

    // byte role inside a three-byte word group
    typedef enum logic [1:0] {
        SUB_HIGH,
        SUB_LOW,
        SUB_CRC
    } sub_t;

    // one complete frame handed from the parser to the converter
    typedef struct packed {
        logic [15:0] co2_word;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
        logic        bad;
    } frame_t;

    function automatic logic [7:0] crc_add(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic sub_t sub_of(input logic [3:0] pos);
        sub_t s;
        case (pos)
            4'd0, 4'd3, 4'd6: s = SUB_HIGH;
            4'd1, 4'd4, 4'd7: s = SUB_LOW;
            default:          s = SUB_CRC;
        endcase
        return s;
    endfunction

endpackage

### src/sensor_frame_crc_decoder.sv
// sensor_frame_crc_decoder: top level. Ties the byte parser, the frame
// queue and the converter together. Depends on sfcd_pkg and sfcd_* modules.
//
// Usage:
//   s_axis carries one frame byte per request: tdata is the byte in wire
//   order, tuser marks the first byte of a frame and resyncs the byte count.
//   Nine bytes form a frame: three 16-bit big-endian words (CO2, temperature,
//   humidity), each followed by its CRC-8 (poly 0x31, init 0xFF).
//   m_axis carries one request per frame: CO2 in ppm, temperature in tenths
//   of a degree (signed), humidity in percent; m_axis_tuser is the CRC error
//   flag, and with it set the values repeat the last good reading (zero
//   before the first good frame).
//   Throughput: one byte per cycle while s_axis_tready is high. The ninth
//   byte's frame passes the queue, the multiply stage and the divide-by-65535
//   correction into the output register, which raises m_axis_tvalid.
//   While m_axis_tready is low, one result waits in the output register, one
//   frame in the multiply stage and two in the queue; s_axis_tready drops
//   only once the queue is full.
//   Reset clears byte position, CRC, queue, last good values and valid flags.
module sensor_frame_crc_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] co2_ppm, [27:16] temp_tenths,
                                        // [34:28] hum_percent, [39:35] zero
    output logic        m_axis_tuser    // [0] crc_error
);

    logic             byte_valid;
    logic             push;
    logic             full;
    logic             pop;
    logic             pop_valid;
    sfcd_pkg::frame_t push_frame;
    sfcd_pkg::frame_t pop_frame;
    logic [15:0]      co2_ppm;
    logic [11:0]      temp_tenths;
    logic [6:0]       hum_percent;

    assign s_axis_tready = !full;
    assign byte_valid    = s_axis_tvalid && !full;

    sfcd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .rx_byte     (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .push        (push),
        .frame       (push_frame)
    );

    sfcd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_frame  (pop_frame)
    );

    sfcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pop_valid),
        .in_frame    (pop_frame),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .co2_ppm     (co2_ppm),
        .temp_tenths (temp_tenths),
        .hum_percent (hum_percent),
        .crc_error   (m_axis_tuser)
    );

    assign m_axis_tdata = {5'd0, hum_percent, temp_tenths, co2_ppm};

endmodule

### src/sfcd_front.sv
// sfcd_front: byte parser. Tracks frame position, checks word CRCs and
// emits one frame record per nine bytes. Depends on sfcd_pkg.
module sfcd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,   // request accepted this cycle
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    output logic                push,
    output sfcd_pkg::frame_t    frame
);

    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] co2_reg, co2_next;
    logic [15:0] temp_reg, temp_next;
    logic [15:0] hum_reg, hum_next;
    logic        bad_reg, bad_next;
    logic [3:0]  pos;
    logic        bad_in;
    logic [15:0] word;

    always_comb
    begin
        pos       = (frame_start || pos_reg > sfcd_pkg::FRAME_LAST) ? 4'd0 : pos_reg;
        bad_in    = (pos == 4'd0) ? 1'b0 : bad_reg;
        word      = {high_reg, rx_byte};
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        high_next = high_reg;
        co2_next  = co2_reg;
        temp_next = temp_reg;
        hum_next  = hum_reg;
        bad_next  = bad_reg;
        push      = 1'b0;
        if (byte_valid)
        begin
            bad_next = bad_in;
            case (sfcd_pkg::sub_of(pos))
                sfcd_pkg::SUB_HIGH:
                begin
                    high_next = rx_byte;
                    crc_next  = sfcd_pkg::crc_add(sfcd_pkg::CRC_SEED, rx_byte);
                end
                sfcd_pkg::SUB_LOW:
                begin
                    crc_next = sfcd_pkg::crc_add(crc_reg, rx_byte);
                    if (pos == 4'd1)
                        co2_next = word;
                    else if (pos == 4'd4)
                        temp_next = word;
                    else
                        hum_next = word;
                end
                default:
                begin
                    if (crc_reg != rx_byte)
                        bad_next = 1'b1;
                    crc_next = sfcd_pkg::CRC_SEED;
                end
            endcase
            if (pos == sfcd_pkg::FRAME_LAST)
            begin
                pos_next = 4'd0;
                push     = 1'b1;
            end
            else
                pos_next = pos + 4'd1;
        end
    end

    // humidity word is complete one byte before the last CRC byte
    assign frame = '{co2_word: co2_reg, temp_word: temp_reg,
                     hum_word: hum_reg, bad: bad_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 4'd0;
            crc_reg  <= sfcd_pkg::CRC_SEED;
            high_reg <= 8'd0;
            co2_reg  <= 16'd0;
            temp_reg <= 16'd0;
            hum_reg  <= 16'd0;
            bad_reg  <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            high_reg <= high_next;
            co2_reg  <= co2_next;
            temp_reg <= temp_next;
            hum_reg  <= hum_next;
            bad_reg  <= bad_next;
        end
    end

endmodule

### src/sfcd_fifo.sv
// sfcd_fifo: two-entry frame queue between parser and converter.
// Depends on sfcd_pkg.
module sfcd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sfcd_pkg::frame_t    push_frame,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output sfcd_pkg::frame_t    pop_frame
);

    sfcd_pkg::frame_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_frame = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/sfcd_back.sv
// sfcd_back: converter. Scales temperature and humidity words, keeps the
// last good reading and drives the output register. Depends on sfcd_pkg.
module sfcd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sfcd_pkg::frame_t    in_frame,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         co2_ppm,
    output logic [11:0]         temp_tenths,
    output logic [6:0]          hum_percent,
    output logic                crc_error
);

    // stage A: products
    logic        a_valid_reg, a_valid_next;
    logic [26:0] a_tprod_reg;
    logic [22:0] a_hprod_reg;
    logic [15:0] a_co2_reg;
    logic        a_bad_reg;
    // last good values and output register
    logic [15:0] last_co2_reg;
    logic [11:0] last_temp_reg;
    logic [6:0]  last_hum_reg;
    logic        o_valid_reg, o_valid_next;
    logic [15:0] o_co2_reg;
    logic [11:0] o_temp_reg;
    logic [6:0]  o_hum_reg;
    logic        o_err_reg;

    logic        out_adv, a_adv;
    logic [10:0] tq0;
    logic [16:0] tr0;
    logic [10:0] tq;
    logic [6:0]  hq0;
    logic [16:0] hr0;
    logic [6:0]  hq;
    logic [11:0] temp_val;

    assign out_adv = !o_valid_reg || out_ready;
    assign a_adv   = a_valid_reg && out_adv;
    assign pop     = in_valid && (!a_valid_reg || a_adv);

    // x / 65535: q0 = x >> 16, remainder q0 + low half, one correction step
    always_comb
    begin
        tq0      = a_tprod_reg[26:16];
        tr0      = {1'b0, a_tprod_reg[15:0]} + {6'd0, tq0};
        tq       = tq0 + {10'd0, (tr0 >= sfcd_pkg::FULL_SCALE)};
        hq0      = a_hprod_reg[22:16];
        hr0      = {1'b0, a_hprod_reg[15:0]} + {10'd0, hq0};
        hq       = hq0 + {6'd0, (hr0 >= sfcd_pkg::FULL_SCALE)};
        temp_val = {1'b0, tq} - sfcd_pkg::TEMP_OFFSET;
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (pop)
            a_valid_next = 1'b1;
        else if (a_adv)
            a_valid_next = 1'b0;
        o_valid_next = o_valid_reg;
        if (a_adv)
            o_valid_next = 1'b1;
        else if (out_ready)
            o_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            o_valid_reg   <= 1'b0;
            last_co2_reg  <= 16'd0;
            last_temp_reg <= 12'd0;
            last_hum_reg  <= 7'd0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
            if (a_adv && !a_bad_reg)
            begin
                last_co2_reg  <= a_co2_reg;
                last_temp_reg <= temp_val;
                last_hum_reg  <= hq;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_tprod_reg <= 27'(in_frame.temp_word) * 27'(sfcd_pkg::TEMP_SCALE);
            a_hprod_reg <= 23'(in_frame.hum_word) * 23'(sfcd_pkg::HUM_SCALE);
            a_co2_reg   <= in_frame.co2_word;
            a_bad_reg   <= in_frame.bad;
        end
        if (a_adv)
        begin
            o_err_reg <= a_bad_reg;
            if (a_bad_reg)
            begin
                o_co2_reg  <= last_co2_reg;
                o_temp_reg <= last_temp_reg;
                o_hum_reg  <= last_hum_reg;
            end
            else
            begin
                o_co2_reg  <= a_co2_reg;
                o_temp_reg <= temp_val;
                o_hum_reg  <= hq;
            end
        end
    end

    assign out_valid   = o_valid_reg;
    assign co2_ppm     = o_co2_reg;
    assign temp_tenths = o_temp_reg;
    assign hum_percent = o_hum_reg;
    assign crc_error   = o_err_reg;

endmodule
